### rtl/core/ip6mac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ip6mac_pkg;

  // Table geometry
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned KEY_W    = 2 * HALF_W;
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned STATUS_W = 2;

  // Request kinds; the fourth code is unused and is answered as not found.
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACT
  } state_t;

endpackage

`default_nettype wire

### rtl/core/ipv6_to_mac_translation_table.sv
// A request is latched in S_IDLE, scanned in S_SCAN and applied in S_ACT once the output
// register can take its result. A new request is taken only in S_IDLE, as the single
// 128-bit key comparator visits every slot in turn, one slot per cycle.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n low, synchronous) clears all valid bits, the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module ipv6_to_mac_translation_table
  import ip6mac_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [HALF_W-1:0]   in_ip_high,
  input  wire logic [HALF_W-1:0]   in_ip_low,
  input  wire logic [MAC_W-1:0]    in_mac_in,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [MAC_W-1:0]         out_mac_out
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Table storage: valid bits in flip-flops, keys and MACs in memories.
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [KEY_W-1:0]   key_mem [ENTRIES];
  logic [MAC_W-1:0]   mac_mem [ENTRIES];

  state_t             state_r, state_nxt;

  // Latched request
  op_t                op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [MAC_W-1:0]   mac_r, mac_nxt;

  // Scan address and compare stage
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               issue_r, issue_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [KEY_W-1:0]   rd_key_r;
  logic [MAC_W-1:0]   rd_mac_r;

  // Scan outcome
  logic               hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [MAC_W-1:0]   hit_mac_r, hit_mac_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [MAC_W-1:0]   out_mac_r, out_mac_nxt;

  // Memory write controls
  logic               key_we, mac_we;
  logic [IDX_W-1:0]   wr_idx;

  logic               in_xfer, out_xfer, act_go, slot_match;

  assign in_stall    = (state_r != S_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  assign out_xfer    = out_valid_r && !out_stall;
  assign act_go      = !out_valid_r || !out_stall;
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_mac_out = out_mac_r;

  // The one shared comparator: registered key of the slot under test against the request.
  assign slot_match = valid_r[cmp_idx_r] && (rd_key_r == key_r);

  // Control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    mac_r        <= mac_nxt;
    idx_r        <= idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_mac_r    <= hit_mac_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    out_status_r <= out_status_nxt;
    out_mac_r    <= out_mac_nxt;
  end

  // Memory read port, one slot per cycle at the scan address
  always_ff @(posedge clk) begin
    rd_key_r <= key_mem[idx_r];
    rd_mac_r <= mac_mem[idx_r];
  end

  // Memory write ports
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_idx] <= key_r;
    end
    if (mac_we) begin
      mac_mem[wr_idx] <= mac_r;
    end
  end

  // Sequencer: next state, scan bookkeeping and the final table update
  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    mac_nxt        = mac_r;
    idx_nxt        = idx_r;
    issue_nxt      = issue_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_mac_nxt    = hit_mac_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    out_valid_nxt  = out_valid_r && !out_xfer;
    out_status_nxt = out_status_r;
    out_mac_nxt    = out_mac_r;
    key_we         = 1'b0;
    mac_we         = 1'b0;
    wr_idx         = hit_idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt         = op_t'(in_op);
          key_nxt        = {in_ip_high, in_ip_low};
          mac_nxt        = in_mac_in;
          idx_nxt        = '0;
          issue_nxt      = 1'b1;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end
      end

      S_SCAN: begin
        // Address side: step through every slot once.
        if (issue_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r;
          if (idx_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        // Compare side: note the matching slot and the lowest free slot.
        if (cmp_vld_r) begin
          if (slot_match) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = cmp_idx_r;
            hit_mac_nxt   = rd_mac_r;
          end
          if (!valid_r[cmp_idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx_r;
          end
          if (cmp_idx_r == LAST_IDX) begin
            state_nxt = S_ACT;
          end
        end
      end

      S_ACT: begin
        // Apply the request once the output register can take its result.
        if (act_go) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOT_FOUND;
          out_mac_nxt    = '0;
          state_nxt      = S_IDLE;
          case (op_r)
            OP_ADD: begin
              if (hit_found_r) begin
                mac_we         = 1'b1;
                out_status_nxt = ST_OK;
              end else if (free_found_r) begin
                wr_idx                = free_idx_r;
                key_we                = 1'b1;
                mac_we                = 1'b1;
                valid_nxt[free_idx_r] = 1'b1;
                out_status_nxt        = ST_OK;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            OP_REMOVE: begin
              if (hit_found_r) begin
                valid_nxt[hit_idx_r] = 1'b0;
                out_status_nxt       = ST_OK;
              end
            end
            OP_LOOKUP: begin
              if (hit_found_r) begin
                out_mac_nxt    = hit_mac_r;
                out_status_nxt = ST_OK;
              end
            end
            default: begin
              out_status_nxt = ST_NOT_FOUND;
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A table-full answer is only given when every slot holds an entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (&valid_r))
  else $error("table full reported with a free slot");

  // Only a successful lookup carries a non-zero MAC.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_mac_r == '0))
  else $error("non-zero MAC on a failed request");

  // A recorded hit always points at a valid slot when the update is applied.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACT && hit_found_r) |-> valid_r[hit_idx_r])
  else $error("hit recorded on an invalid slot");

endmodule

`default_nettype wire

### tb/tb_ipv6_to_mac_translation_table.sv
`timescale 1ns / 1ps

module tb_ipv6_to_mac_translation_table;
  import ip6mac_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned KEY_POOL     = 28;
  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned PRESSURE_AT  = 3000;
  localparam int unsigned PRESSURE_LEN = 400;
  localparam int unsigned DRAIN_CYCLES = ENTRIES + 2 + 8;

  // The fourth request code has no enum member; it must be answered as not found.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    status_t          status;
    logic [MAC_W-1:0] mac;
  } reply_t;

  // Shadow copy of the neighbour table and the replies it predicts.
  class neighbour_scoreboard;
    bit                slot_used [ENTRIES];
    logic [HALF_W-1:0] slot_key_hi [ENTRIES];
    logic [HALF_W-1:0] slot_key_lo [ENTRIES];
    logic [MAC_W-1:0]  slot_mac [ENTRIES];
    reply_t            replies[$];
    int                errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      errors = 0;
    endfunction

    function int outstanding();
      return replies.size();
    endfunction

    // Apply one accepted request to the shadow table and queue its reply.
    function void note_request(logic [OP_W-1:0] op, logic [HALF_W-1:0] hi,
                               logic [HALF_W-1:0] lo, logic [MAC_W-1:0] mac);
      int     hit;
      int     spare;
      reply_t r;
      hit   = -1;
      spare = -1;
      // Scanning downwards leaves the lowest matching and lowest free index.
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_key_hi[i] == hi && slot_key_lo[i] == lo) hit = i;
        if (!slot_used[i]) spare = i;
      end
      r.status = ST_NOT_FOUND;
      r.mac    = '0;
      case (op)
        OP_ADD: begin
          if (hit >= 0) begin
            slot_mac[hit] = mac;
            r.status      = ST_OK;
          end else if (spare >= 0) begin
            slot_used[spare]   = 1'b1;
            slot_key_hi[spare] = hi;
            slot_key_lo[spare] = lo;
            slot_mac[spare]    = mac;
            r.status           = ST_OK;
          end else begin
            r.status = ST_FULL;
          end
        end
        OP_REMOVE: begin
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            r.status       = ST_OK;
          end
        end
        OP_LOOKUP: begin
          if (hit >= 0) begin
            r.status = ST_OK;
            r.mac    = slot_mac[hit];
          end
        end
        default: ;
      endcase
      replies.push_back(r);
    endfunction

    // Compare one result transfer with the oldest predicted reply.
    function void check_reply(logic [STATUS_W-1:0] status, logic [MAC_W-1:0] mac);
      reply_t want;
      if (replies.size() == 0) begin
        $error("unexpected result: status %0d, mac_out %h", status, mac);
        errors++;
        return;
      end
      want = replies.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (mac !== want.mac) begin
        $error("mac_out: expected %h, actual %h", want.mac, mac);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_op;
  logic [HALF_W-1:0] in_ip_high;
  logic [HALF_W-1:0] in_ip_low;
  logic [MAC_W-1:0]  in_mac_in;
  logic              out_valid;
  logic              out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [MAC_W-1:0]  out_mac_out;

  neighbour_scoreboard board;
  int unsigned         cycle_count;
  bit                  sender_calm;
  logic [HALF_W-1:0]   pool_hi [KEY_POOL];
  logic [HALF_W-1:0]   pool_lo [KEY_POOL];

  ipv6_to_mac_translation_table uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_ip_high  (in_ip_high),
    .in_ip_low   (in_ip_low),
    .in_mac_in   (in_mac_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_mac_out (out_mac_out)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Cycle counter with a hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_span(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  // Offer one request and wait for its transfer. Valid stays high when no gap is taken.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [HALF_W-1:0] hi,
                              input logic [HALF_W-1:0] lo, input logic [MAC_W-1:0] mac);
    int gap;
    gap = idle_span(sender_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_ip_high <= hi;
    in_ip_low  <= lo;
    in_mac_in  <= mac;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(op, hi, lo, mac);
  endtask

  // Result side: check each transfer and stall at random, with one long hold-off.
  initial begin : result_sink
    int stall_left;
    bit sink_calm;
    bit pressure_done;
    stall_left    = 0;
    sink_calm     = 1'b0;
    pressure_done = 1'b0;
    out_stall     = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_reply(out_status, out_mac_out);
      if (cycle_count % 256 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!pressure_done && cycle_count >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        stall_left    = PRESSURE_LEN;
      end else begin
        stall_left = idle_span(sink_calm);
      end
      out_stall <= (stall_left > 0);
    end
  end

  initial begin : stimulus
    logic [OP_W-1:0]   op;
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo;
    logic [MAC_W-1:0]  mac;
    int                pool_size;
    int                roll;
    int                k;

    board       = new();
    sender_calm = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_op       = OP_ADD;
    in_ip_high  = '0;
    in_ip_low   = '0;
    in_mac_in   = '0;

    // Key pool; some neighbours share one half of the key to catch half-key matches.
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_hi[i] = (i % 4 == 1) ? pool_hi[i - 1] : rand64();
      pool_lo[i] = (i % 4 == 3) ? pool_lo[i - 1] : rand64();
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: every search misses, and the unused code misses too.
    send_request(OP_LOOKUP, '1, '1, '0);
    send_request(OP_REMOVE, '0, '0, '0);
    send_request(OP_UNUSED, '1, '1, '1);

    // Extreme keys and MACs, replacement in place, half-key mismatches.
    send_request(OP_ADD, '0, '0, '0);
    send_request(OP_ADD, '1, '1, '1);
    send_request(OP_LOOKUP, '0, '0, '0);
    send_request(OP_LOOKUP, '1, '1, '0);
    send_request(OP_ADD, '0, '0, 48'h5a5a_a5a5_5a5a);
    send_request(OP_LOOKUP, '0, '0, '0);
    send_request(OP_LOOKUP, '0, '1, '0);
    send_request(OP_LOOKUP, '1, '0, '0);
    send_request(OP_REMOVE, '0, '0, '0);
    send_request(OP_LOOKUP, '0, '0, '0);

    // Fill the table; the first add lands in the freed lowest slot.
    for (int i = 0; i < ENTRIES - 1; i++)
      send_request(OP_ADD, 64'h0001_0000_0000_0000 + 64'(i), ~64'(i), 48'(rand64()));

    // Full table: a new key is refused, a present key is still replaced.
    send_request(OP_ADD, 64'hfe80_0000_0000_0000, 64'h1, 48'h0200_0000_0001);
    send_request(OP_ADD, '1, '1, 48'h0123_4567_89ab);
    send_request(OP_REMOVE, 64'h0001_0000_0000_0007, ~64'(7), '0);
    send_request(OP_ADD, 64'hfe80_0000_0000_0000, 64'h1, 48'h0200_0000_0001);
    send_request(OP_LOOKUP, 64'hfe80_0000_0000_0000, 64'h1, '0);

    // Empty the table again so the random part starts from a clean state.
    for (int i = 0; i < ENTRIES - 1; i++)
      send_request(OP_REMOVE, 64'h0001_0000_0000_0000 + 64'(i), ~64'(i), '0);
    send_request(OP_REMOVE, '1, '1, '0);
    send_request(OP_REMOVE, 64'hfe80_0000_0000_0000, 64'h1, '0);

    // Random traffic over a key pool whose active size varies per chunk.
    pool_size = KEY_POOL;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        pool_size   = $urandom_range(2, KEY_POOL);
        sender_calm = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      mac  = 48'(rand64());
      if (roll < 8) begin
        // Noise: arbitrary key and any code, the unused one included.
        op = 2'($urandom_range(0, 3));
        hi = rand64();
        lo = rand64();
      end else begin
        k  = $urandom_range(0, pool_size - 1);
        hi = pool_hi[k];
        lo = pool_lo[k];
        roll = $urandom_range(0, 99);
        if (roll < 45) op = OP_ADD;
        else if (roll < 65) op = OP_REMOVE;
        else op = OP_LOOKUP;
      end
      send_request(op, hi, lo, mac);
    end
    in_valid <= 1'b0;

    // Drain outstanding replies, then allow for any stray late transfer.
    while (board.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### ipv6_to_mac_translation_table.f
rtl/core/ip6mac_pkg.sv
rtl/core/ipv6_to_mac_translation_table.sv
tb/tb_ipv6_to_mac_translation_table.sv
